@@ design/bpnm_pkg.sv @@
package bpnm_pkg;

   // default sizes
   localparam int MAX_INPUTS_DEF = 256;
   localparam int FRAC_BITS_DEF  = 12;

   // fixed field widths
   localparam int ACC_WIDTH = 40;
   localparam int VAL_WIDTH = 16;

   localparam logic signed [ACC_WIDTH-1:0] ACC_HI = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_LO = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   // actions
   localparam logic [2:0] ACT_LOAD    = 3'd0;
   localparam logic [2:0] ACT_FORWARD = 3'd1;
   localparam logic [2:0] ACT_OUTGRAD = 3'd2;
   localparam logic [2:0] ACT_HIDDEN  = 3'd3;
   localparam logic [2:0] ACT_UPDATE  = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_OUTPUT   = 2'd0;
   localparam logic [1:0] KIND_GRADIENT = 2'd1;
   localparam logic [1:0] KIND_WEIGHT   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_LEARN_RATE = 2'd0;
   localparam logic [1:0] CSR_MOMENTUM   = 2'd1;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_ACC, S_TANH, S_G_SQ, S_G_DRV, S_G_MUL, S_G_FIN,
      S_U_MUL, S_U_SCALE, S_U_FIN, S_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      T_IDLE, T_EXP, T_PREP, T_DIV, T_DONE
   } tanh_state_type;

   typedef struct packed {
      logic                         start;
      logic signed [ACC_WIDTH-1:0]  sum;
   } tanh_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [VAL_WIDTH-1:0]  value;
   } tanh_rsp_type;

   typedef struct packed {
      logic                         sat;
      logic signed [VAL_WIDTH-1:0]  value;
   } clip_type;

   // shift right, round to nearest, ties away from zero
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      if (v >= 0) return (v + half) >>> s;
      else return -((-v + half) >>> s);
   endfunction

   // clip to 16 bits signed
   function automatic clip_type clip16(input logic signed [63:0] v);
      clip_type r;
      if (v > 64'sd32767) begin
         r.sat = 1'b1; r.value = 16'sh7FFF;
      end else if (v < -64'sd32768) begin
         r.sat = 1'b1; r.value = 16'sh8000;
      end else begin
         r.sat = 1'b0; r.value = v[15:0];
      end
      return r;
   endfunction

   // exp(-2^j) in Q1.30, index = j + 14
   function automatic logic [30:0] exp_tab_q30(input logic [4:0] idx);
      logic [30:0] r;
      unique case (idx)
         5'd0:  r = 31'd1073676290;
         5'd1:  r = 31'd1073610760;
         5'd2:  r = 31'd1073479712;
         5'd3:  r = 31'd1073217664;
         5'd4:  r = 31'd1072693760;
         5'd5:  r = 31'd1071646719;
         5'd6:  r = 31'd1069555701;
         5'd7:  r = 31'd1065385899;
         5'd8:  r = 31'd1057095000;
         5'd9:  r = 31'd1040706261;
         5'd10: r = 31'd1008687096;
         5'd11: r = 31'd947573834;
         5'd12: r = 31'd836230973;
         5'd13: r = 31'd651257337;
         5'd14: r = 31'd395007542;
         5'd15: r = 31'd145315154;
         5'd16: r = 31'd19666268;
         5'd17: r = 31'd360200;
         default: r = 31'd0;
      endcase
      return r;
   endfunction

endpackage

@@ design/backprop_neuron_momentum.sv @@
// Channel | Direction | Handshake            | Payload
// req     | in        | req_tvalid/tready    | tdata slot,value,partner; tuser action; tlast
// rsp     | out       | rsp_tvalid/tready    | tdata result_value; tuser kind,saturated
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One item at a time; the weight and delta RAMs are read on accept, data in the next cycle.
// Tanh: FRAC_BITS+4 exp steps, setup, one quotient bit per cycle, done; straight to done
// when the sum is out of range. Reset is synchronous; RAMs are not cleared.
// A result waits in the output register; the next item is accepted meanwhile, and the
// sequencer stalls at emit while that register is still full.
module backprop_neuron_momentum #(
   parameter int MAX_INPUTS = bpnm_pkg::MAX_INPUTS_DEF,
   parameter int FRAC_BITS  = bpnm_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // slot[7:0], value[23:8], partner[39:24]
   input  logic [2:0]  req_tuser,   // action[2:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result_value[15:0]
   output logic [2:0]  rsp_tuser,   // result_kind[1:0], saturated[2]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bpnm_pkg::*;

   localparam int AW = $clog2(MAX_INPUTS);
   localparam int GW = 41 - FRAC_BITS;     // gradient operand
   localparam int DW = 34 - FRAC_BITS;     // derivative
   localparam int RW = GW + DW;

   // slot modulo memory depth, one subtract per bit
   function automatic logic [AW-1:0] slot_mod(input logic [7:0] s);
      logic [19:0] r;
      r = 20'(s);
      for (int k = 7; k >= 0; k--) begin
         if (r >= (20'(MAX_INPUTS) << k)) r = r - (20'(MAX_INPUTS) << k);
      end
      return AW'(r);
   endfunction

   top_state_type               state_ff, state_in;
   logic [2:0]                  action_ff;
   logic                        last_ff;
   logic [AW-1:0]               slot_ff;
   logic signed [15:0]          value_ff, partner_ff;
   logic signed [ACC_WIDTH-1:0] acc_ff;
   logic signed [31:0]          prod_ff;
   logic signed [15:0]          out_ff, grad_ff;
   logic [15:0]                 lr_ff, mf_ff;
   logic signed [GW-1:0]        ga_ff;
   logic [31:0]                 sq_ff;
   logic signed [DW-1:0]        drv_ff;
   logic signed [RW-1:0]        gp_ff;
   logic signed [31:0]          p1_ff;
   logic signed [32:0]          pm_ff;
   logic signed [48:0]          lt_ff;
   logic signed [63:0]          mt_ff;
   logic [1:0]                  kind_ff;
   logic signed [15:0]          res_ff;
   logic                        sat_ff;
   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_kind_ff;
   logic [15:0]                 rsp_value_ff;
   logic                        rsp_sat_ff;

   logic                        req_fire;
   logic                        emit_go;
   logic                        ram_wr;
   logic [15:0]                 w_wr, d_wr;
   logic [15:0]                 w_rd, d_rd;
   logic signed [40:0]          acc_sum;
   logic signed [ACC_WIDTH-1:0] acc_new;
   clip_type                    g_clip, d_clip, w_clip;
   tanh_req_type                tanh_req;
   tanh_rsp_type                tanh_rsp;

   assign req_fire  = req_tvalid && req_tready;
   assign emit_go   = state_ff == S_EMIT && (!rsp_valid_ff || rsp_tready);
   assign csr_ready = 1'b1;

   // weight and delta memories
   bpnm_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_weight (
      .clock(clock), .wr_en(ram_wr), .wr_addr(slot_ff), .wr_data(w_wr),
      .rd_en(req_fire), .rd_addr(slot_mod(req_tdata[7:0])), .rd_data(w_rd));

   bpnm_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_delta (
      .clock(clock), .wr_en(ram_wr), .wr_addr(slot_ff), .wr_data(d_wr),
      .rd_en(req_fire), .rd_addr(slot_mod(req_tdata[7:0])), .rd_data(d_rd));

   bpnm_tanh #(.FRAC_BITS(FRAC_BITS)) u_tanh (
      .clock(clock), .reset(reset), .req(tanh_req), .rsp(tanh_rsp));

   // saturating accumulate
   always_comb begin
      acc_sum = 41'(acc_ff) + 41'(prod_ff);
      if (acc_sum[40] != acc_sum[39]) acc_new = acc_sum[40] ? ACC_LO : ACC_HI;
      else acc_new = acc_sum[39:0];
   end

   // gradient, delta and weight clipping
   always_comb begin
      g_clip = clip16(rnd_shift(64'(gp_ff), FRAC_BITS));
      d_clip = clip16(rnd_shift(64'(lt_ff) + mt_ff, 16 + FRAC_BITS));
      w_clip = clip16(64'(signed'(w_rd)) + 64'(d_clip.value));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_fire) state_in = S_EXEC;
         S_EXEC: begin
            unique case (action_ff)
               ACT_FORWARD, ACT_HIDDEN: state_in = S_ACC;
               ACT_OUTGRAD:             state_in = S_G_SQ;
               ACT_UPDATE:              state_in = S_U_MUL;
               default:                 state_in = S_IDLE;
            endcase
         end
         S_ACC: begin
            if (!last_ff) state_in = S_IDLE;
            else if (action_ff == ACT_FORWARD) state_in = S_TANH;
            else state_in = S_G_SQ;
         end
         S_TANH:    if (tanh_rsp.done) state_in = S_EMIT;
         S_G_SQ:    state_in = S_G_DRV;
         S_G_DRV:   state_in = S_G_MUL;
         S_G_MUL:   state_in = S_G_FIN;
         S_G_FIN:   state_in = S_EMIT;
         S_U_MUL:   state_in = S_U_SCALE;
         S_U_SCALE: state_in = S_U_FIN;
         S_U_FIN:   state_in = S_EMIT;
         S_EMIT:    if (emit_go) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready   = state_ff == S_IDLE;
      ram_wr       = 1'b0;
      w_wr         = value_ff;
      d_wr         = '0;
      tanh_req.start = state_ff == S_ACC && last_ff && action_ff == ACT_FORWARD;
      tanh_req.sum   = acc_new;
      if (state_ff == S_EXEC && action_ff == ACT_LOAD) ram_wr = 1'b1;
      if (state_ff == S_U_FIN) begin
         ram_wr = 1'b1;
         w_wr   = w_clip.value;
         d_wr   = d_clip.value;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         out_ff       <= '0;
         grad_ff      <= '0;
         lr_ff        <= 16'd9830;
         mf_ff        <= 16'd32768;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_index == CSR_LEARN_RATE) lr_ff <= csr_data;
         if (csr_valid && csr_index == CSR_MOMENTUM) mf_ff <= csr_data;
         if (state_ff == S_ACC) acc_ff <= last_ff ? '0 : acc_new;
         if (state_ff == S_TANH && tanh_rsp.done) out_ff <= tanh_rsp.value;
         if (state_ff == S_G_FIN) grad_ff <= g_clip.value;
         if (emit_go) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff  <= req_tuser;
         last_ff    <= req_tlast;
         slot_ff    <= slot_mod(req_tdata[7:0]);
         value_ff   <= req_tdata[23:8];
         partner_ff <= req_tdata[39:24];
      end
      unique case (state_ff)
         S_EXEC: begin
            if (action_ff == ACT_HIDDEN) prod_ff <= 32'(value_ff) * 32'(partner_ff);
            else prod_ff <= 32'(value_ff) * 32'(signed'(w_rd));
            ga_ff <= GW'(17'(value_ff) - 17'(out_ff));
         end
         S_ACC:   ga_ff <= GW'(rnd_shift(64'(acc_new), FRAC_BITS));
         S_TANH: begin
            kind_ff <= KIND_OUTPUT;
            res_ff  <= tanh_rsp.value;
            sat_ff  <= 1'b0;
         end
         S_G_SQ:  sq_ff <= 32'(32'(out_ff) * 32'(out_ff));
         S_G_DRV: drv_ff <= DW'(1 << FRAC_BITS) - DW'((sq_ff + 32'(1 << (FRAC_BITS - 1)))
                                                      >> FRAC_BITS);
         S_G_MUL: gp_ff <= RW'(ga_ff) * RW'(drv_ff);
         S_G_FIN: begin
            kind_ff <= KIND_GRADIENT;
            res_ff  <= g_clip.value;
            sat_ff  <= g_clip.sat;
         end
         S_U_MUL: begin
            p1_ff <= 32'(value_ff) * 32'(grad_ff);
            pm_ff <= 33'(signed'({1'b0, mf_ff})) * 33'(signed'(d_rd));
         end
         S_U_SCALE: begin
            lt_ff <= 49'(signed'({1'b0, lr_ff})) * 49'(p1_ff);
            mt_ff <= 64'(pm_ff) <<< FRAC_BITS;
         end
         S_U_FIN: begin
            kind_ff <= KIND_WEIGHT;
            res_ff  <= w_clip.value;
            sat_ff  <= d_clip.sat || w_clip.sat;
         end
         default: ;
      endcase
      if (emit_go) begin
         rsp_kind_ff  <= kind_ff;
         rsp_value_ff <= res_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_kind_ff};

   // a free output register takes the result
   a_emit: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> rsp_valid_ff)
      else $error("result not shown after emit");

   // memories are written only by load and update
   a_wr: assert property (@(posedge clock) disable iff (reset)
      ram_wr |-> (state_ff == S_EXEC && action_ff == ACT_LOAD) || state_ff == S_U_FIN)
      else $error("unexpected memory write");

   // tanh finishes only while the sequencer waits for it
   a_tanh: assert property (@(posedge clock) disable iff (reset)
      tanh_rsp.done |-> state_ff == S_TANH)
      else $error("stray tanh completion");

   // neuron outputs never clip
   a_out_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_OUTPUT) |-> !rsp_sat_ff)
      else $error("neuron output flagged saturated");

   // a run ends with a cleared accumulator
   a_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC && last_ff) |=> acc_ff == '0)
      else $error("accumulator not cleared");

endmodule

@@ design/bpnm_ram.sv @@
module bpnm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // registered read, hold between reads
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bpnm_tanh.sv @@
module bpnm_tanh #(
   parameter int FRAC_BITS = bpnm_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bpnm_pkg::tanh_req_type req,
   output bpnm_pkg::tanh_rsp_type rsp
);
   import bpnm_pkg::*;

   localparam int YW = FRAC_BITS + 4;       // bits of 2|x|
   localparam int QW = FRAC_BITS + 1;       // quotient bits
   localparam int CW = $clog2(YW);
   localparam int NW = FRAC_BITS + 33;      // divider width
   localparam int MW = ACC_WIDTH + 1;

   tanh_state_type    state_ff, state_in;
   logic              neg_ff, neg_in;
   logic [YW-1:0]     y_ff, y_in;
   logic [30:0]       e_ff, e_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [NW-1:0]     rem_ff, rem_in;
   logic [NW-1:0]     dsh_ff, dsh_in;
   logic [QW-1:0]     q_ff, q_in;

   logic [MW-1:0]     abs_sum;
   logic [MW-1:0]     mag;
   logic [61:0]       eprod;
   logic [61:0]       eround;
   logic [31:0]       den;
   logic [NW-1:0]     num;
   logic              ge;

   // magnitude of the sum, rounded to the output fraction
   always_comb begin
      abs_sum = req.sum[ACC_WIDTH-1] ? MW'(-(MW'(signed'(req.sum))))
                                     : MW'(req.sum);
      mag     = (abs_sum + MW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
   end

   // one exponent factor per step
   always_comb begin
      eprod  = 62'(e_ff) * 62'(exp_tab_q30(5'(cnt_ff) + 5'(14 - FRAC_BITS)));
      eround = (eprod + 62'(64'd1 << 29)) >> 30;
   end

   // quotient setup and divide step
   always_comb begin
      den = 32'(ONE_Q30) + 32'(e_ff);
      num = (NW'(ONE_Q30 - e_ff) << FRAC_BITS) + NW'(den >> 1);
      ge  = rem_ff >= dsh_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: if (req.start) state_in = (mag >= MW'(8 << FRAC_BITS)) ? T_DONE : T_EXP;
         T_EXP:  if (cnt_ff == CW'(YW - 1)) state_in = T_PREP;
         T_PREP: state_in = T_DIV;
         T_DIV:  if (cnt_ff == CW'(QW - 1)) state_in = T_DONE;
         T_DONE: state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      neg_in = neg_ff;
      y_in   = y_ff;
      e_in   = e_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      unique case (state_ff)
         T_IDLE: begin
            neg_in = req.sum[ACC_WIDTH-1];
            y_in   = YW'(mag << 1);
            e_in   = ONE_Q30;
            cnt_in = '0;
            q_in   = QW'(1 << FRAC_BITS);
         end
         T_EXP: begin
            if (y_ff[cnt_ff]) e_in = eround[30:0];
            cnt_in = cnt_ff + CW'(1);
         end
         T_PREP: begin
            rem_in = num;
            dsh_in = NW'(den) << FRAC_BITS;
            q_in   = '0;
            cnt_in = '0;
         end
         T_DIV: begin
            if (ge) rem_in = rem_ff - dsh_ff;
            dsh_in = dsh_ff >> 1;
            q_in   = {q_ff[QW-2:0], ge};
            cnt_in = cnt_ff + CW'(1);
         end
         T_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= T_IDLE;
      else state_ff <= state_in;
      neg_ff <= neg_in;
      y_ff   <= y_in;
      e_ff   <= e_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   // outputs
   always_comb begin
      rsp.done  = state_ff == T_DONE;
      rsp.value = neg_ff ? -VAL_WIDTH'(signed'({1'b0, q_ff}))
                         : VAL_WIDTH'(signed'({1'b0, q_ff}));
   end

endmodule
